// ----- rtl/iem_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iem_pkg: shared types and constants of the I2C EEPROM master
// Phase and stage codes, request codes, register indexes, item layouts.
// ----------------------------------------------------------------------------
package iem_pkg;

    // request kinds carried on s_tuser
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_DEV_ADDR    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_LIMIT   = 2'd2;

    // register reset values
    localparam logic [6:0] DEV_ADDR_RST    = 7'd80;
    localparam logic [9:0] PHASE_TICKS_RST = 10'd20;
    localparam logic [9:0] ACK_LIMIT_RST   = 10'd500;

    localparam int MAX_READ_LEN_DEF = 256;

    // item layouts
    localparam int IN_DATA_W  = 40;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 16;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_ST_HIGH,
        PH_ST_FALL,
        PH_RS_LOW,
        PH_RS_HIGH,
        PH_RS_FALL,
        PH_RX_LOW,
        PH_RX_HIGH,
        PH_TX_LOW,
        PH_TX_HIGH,
        PH_ACK_LOW,
        PH_ACK_HIGH,
        PH_MACK_LOW,
        PH_MACK_HIGH,
        PH_SP_LOW,
        PH_SP_HIGH
    } phase_t;

    typedef enum logic [2:0] {
        STG_DEVW,
        STG_AHI,
        STG_ALO,
        STG_DATA,
        STG_DEVR
    } stage_t;

    typedef struct packed {
        logic [6:0] dev_addr;
        logic [9:0] phase_ticks;
        logic [9:0] ack_limit;
    } cfg_t;

    typedef struct packed {
        logic       done;
        logic       ack_missing;
        logic       last;
        logic [7:0] rbyte;
        logic       valid;
        logic       busy;
        logic       pull;
        logic       scl;
    } res_t;

endpackage

// ----- rtl/iem_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iem_ctrl: bus sequencer of the I2C EEPROM master
// Steps the phase machine once per accepted tick and forms the result item.
// ----------------------------------------------------------------------------
module iem_ctrl
    import iem_pkg::*;
#(
    parameter int MAX_READ_LEN = MAX_READ_LEN_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [1:0]  action,
    input  logic [15:0] mem_addr,
    input  logic [7:0]  write_data,
    input  logic [8:0]  read_length,
    input  logic        sda_in,
    input  cfg_t        cfg,
    output res_t        res
);

    localparam int LEN_RAW_W = $clog2(MAX_READ_LEN + 1);
    localparam int BL_W = (LEN_RAW_W < 9) ? LEN_RAW_W : 9;

    phase_t          phase_reg, phase_next;
    stage_t          stage_reg, stage_next;
    logic [9:0]      pcnt_reg, pcnt_next;
    logic [3:0]      bcnt_reg, bcnt_next;
    logic [7:0]      sbyte_reg, sbyte_next;
    logic [BL_W-1:0] bleft_reg, bleft_next;
    logic [15:0]     haddr_reg, haddr_next;
    logic [7:0]      hdata_reg, hdata_next;
    logic            is_read_reg, is_read_next;
    logic [9:0]      awc_reg, awc_next;
    logic            err_reg, err_next;

    logic            rx_valid, rx_last, stop_done;
    logic [7:0]      rx_byte;

    logic [10:0]     cnt_inc;
    logic [8:0]      len_min;
    logic [8:0]      len_sat;
    logic [3:0]      bcnt_inc;
    logic [7:0]      sbyte_rx;
    logic [9:0]      awc_inc;
    logic [BL_W-1:0] bleft_dec;

    function automatic logic [7:0] stage_byte(stage_t s, logic [6:0] dev, logic [15:0] a,
                                              logic [7:0] d);
        case (s)
            STG_DEVW: stage_byte = {dev, 1'b0};
            STG_AHI:  stage_byte = a[15:8];
            STG_ALO:  stage_byte = a[7:0];
            STG_DATA: stage_byte = d;
            default:  stage_byte = {dev, 1'b1};
        endcase
    endfunction

    assign cnt_inc  = {1'b0, pcnt_reg} + 11'd1;
    assign len_min  = (read_length == 9'd0) ? 9'd1 : read_length;
    assign len_sat  = ({8'd0, len_min} > 17'(MAX_READ_LEN)) ? 9'(MAX_READ_LEN) : len_min;
    assign bcnt_inc = bcnt_reg + 4'd1;
    assign sbyte_rx = {sbyte_reg[6:0], sda_in};
    assign awc_inc  = awc_reg + 10'd1;
    assign bleft_dec = (bleft_reg != '0) ? bleft_reg - BL_W'(1) : bleft_reg;

    // next state
    always_comb
    begin
        phase_next   = phase_reg;
        stage_next   = stage_reg;
        pcnt_next    = pcnt_reg;
        bcnt_next    = bcnt_reg;
        sbyte_next   = sbyte_reg;
        bleft_next   = bleft_reg;
        haddr_next   = haddr_reg;
        hdata_next   = hdata_reg;
        is_read_next = is_read_reg;
        awc_next     = awc_reg;
        err_next     = err_reg;
        rx_valid     = 1'b0;
        rx_byte      = 8'd0;
        rx_last      = 1'b0;
        stop_done    = 1'b0;

        if (phase_reg == PH_IDLE)
        begin
            if (action == ACT_WRITE || action == ACT_READ)
            begin
                haddr_next   = mem_addr;
                hdata_next   = write_data;
                is_read_next = (action == ACT_READ);
                bleft_next   = (action == ACT_READ) ? BL_W'(len_sat) : '0;
                err_next     = 1'b0;
                awc_next     = 10'd0;
                bcnt_next    = 4'd0;
                sbyte_next   = 8'd0;
                pcnt_next    = 10'd0;
                phase_next   = PH_ST_HIGH;
            end
        end
        else if (cnt_inc < {1'b0, cfg.phase_ticks})
        begin
            pcnt_next = cnt_inc[9:0];
        end
        else
        begin
            pcnt_next = 10'd0;
            case (phase_reg)
                PH_ST_HIGH: phase_next = PH_ST_FALL;
                PH_ST_FALL:
                begin
                    phase_next = PH_TX_LOW;
                    stage_next = STG_DEVW;
                    sbyte_next = stage_byte(STG_DEVW, cfg.dev_addr, haddr_reg, hdata_reg);
                    bcnt_next  = 4'd0;
                end
                PH_RS_LOW:  phase_next = PH_RS_HIGH;
                PH_RS_HIGH: phase_next = PH_RS_FALL;
                PH_RS_FALL:
                begin
                    phase_next = PH_TX_LOW;
                    stage_next = STG_DEVR;
                    sbyte_next = stage_byte(STG_DEVR, cfg.dev_addr, haddr_reg, hdata_reg);
                    bcnt_next  = 4'd0;
                end
                PH_RX_LOW:  phase_next = PH_RX_HIGH;
                PH_RX_HIGH:
                begin
                    sbyte_next = sbyte_rx;
                    bcnt_next  = bcnt_inc;
                    if (bcnt_inc >= 4'd8)
                    begin
                        rx_valid   = 1'b1;
                        rx_byte    = sbyte_rx;
                        rx_last    = (bleft_reg <= BL_W'(1));
                        phase_next = PH_MACK_LOW;
                    end
                    else
                    begin
                        phase_next = PH_RX_LOW;
                    end
                end
                PH_MACK_LOW: phase_next = PH_MACK_HIGH;
                PH_MACK_HIGH:
                begin
                    bleft_next = bleft_dec;
                    if (bleft_dec == '0)
                    begin
                        phase_next = PH_SP_LOW;
                    end
                    else
                    begin
                        phase_next = PH_RX_LOW;
                        bcnt_next  = 4'd0;
                        sbyte_next = 8'd0;
                    end
                end
                PH_SP_LOW:  phase_next = PH_SP_HIGH;
                PH_SP_HIGH:
                begin
                    phase_next = PH_IDLE;
                    stop_done  = 1'b1;
                end
                PH_TX_LOW:  phase_next = PH_TX_HIGH;
                PH_TX_HIGH:
                begin
                    sbyte_next = {sbyte_reg[6:0], 1'b0};
                    bcnt_next  = bcnt_inc;
                    phase_next = (bcnt_inc >= 4'd8) ? PH_ACK_LOW : PH_TX_LOW;
                end
                PH_ACK_LOW:
                begin
                    awc_next   = 10'd0;
                    phase_next = PH_ACK_HIGH;
                end
                PH_ACK_HIGH:
                begin
                    if (sda_in && (awc_inc < cfg.ack_limit))
                    begin
                        // keep waiting: hold the phase count where it was
                        awc_next  = awc_inc;
                        pcnt_next = pcnt_reg;
                    end
                    else
                    begin
                        if (sda_in)
                        begin
                            awc_next = awc_inc;
                            err_next = 1'b1;
                        end
                        // move on to what follows the acknowledged byte
                        case (stage_reg)
                            STG_DEVW:
                            begin
                                phase_next = PH_TX_LOW;
                                stage_next = STG_AHI;
                                sbyte_next = stage_byte(STG_AHI, cfg.dev_addr, haddr_reg,
                                                        hdata_reg);
                                bcnt_next  = 4'd0;
                            end
                            STG_AHI:
                            begin
                                phase_next = PH_TX_LOW;
                                stage_next = STG_ALO;
                                sbyte_next = stage_byte(STG_ALO, cfg.dev_addr, haddr_reg,
                                                        hdata_reg);
                                bcnt_next  = 4'd0;
                            end
                            STG_ALO:
                            begin
                                if (is_read_reg)
                                begin
                                    phase_next = PH_RS_LOW;
                                end
                                else
                                begin
                                    phase_next = PH_TX_LOW;
                                    stage_next = STG_DATA;
                                    sbyte_next = stage_byte(STG_DATA, cfg.dev_addr, haddr_reg,
                                                            hdata_reg);
                                    bcnt_next  = 4'd0;
                                end
                            end
                            STG_DATA: phase_next = PH_SP_LOW;
                            default:
                            begin
                                phase_next = PH_RX_LOW;
                                bcnt_next  = 4'd0;
                                sbyte_next = 8'd0;
                            end
                        endcase
                    end
                end
                default: phase_next = PH_IDLE;
            endcase
        end
    end

    // line levels and result item, taken from the updated state
    always_comb
    begin
        res             = '0;
        res.scl         = 1'b1;
        res.pull        = 1'b0;
        res.busy        = (phase_next != PH_IDLE);
        res.valid       = rx_valid;
        res.rbyte       = rx_byte;
        res.last        = rx_last;
        res.ack_missing = err_next;
        res.done        = stop_done;
        case (phase_next)
            PH_ST_FALL, PH_RS_FALL, PH_SP_HIGH: res.pull = 1'b1;
            PH_RS_LOW, PH_RX_LOW, PH_ACK_LOW:   res.scl = 1'b0;
            PH_MACK_LOW:
            begin
                res.scl  = 1'b0;
                res.pull = (bleft_next > BL_W'(1));
            end
            PH_MACK_HIGH: res.pull = (bleft_next > BL_W'(1));
            PH_SP_LOW:
            begin
                res.scl  = 1'b0;
                res.pull = 1'b1;
            end
            PH_TX_LOW:
            begin
                res.scl  = 1'b0;
                res.pull = ~sbyte_next[7];
            end
            PH_TX_HIGH: res.pull = ~sbyte_next[7];
            default:    res.scl = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            stage_reg   <= STG_DEVW;
            pcnt_reg    <= 10'd0;
            bcnt_reg    <= 4'd0;
            sbyte_reg   <= 8'd0;
            bleft_reg   <= '0;
            haddr_reg   <= 16'd0;
            hdata_reg   <= 8'd0;
            is_read_reg <= 1'b0;
            awc_reg     <= 10'd0;
            err_reg     <= 1'b0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            stage_reg   <= stage_next;
            pcnt_reg    <= pcnt_next;
            bcnt_reg    <= bcnt_next;
            sbyte_reg   <= sbyte_next;
            bleft_reg   <= bleft_next;
            haddr_reg   <= haddr_next;
            hdata_reg   <= hdata_next;
            is_read_reg <= is_read_next;
            awc_reg     <= awc_next;
            err_reg     <= err_next;
        end
    end

endmodule

// ----- rtl/i2c_eeprom_master_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_eeprom_master_core: tick-driven I2C master for two-byte-addressed EEPROMs
// Byte write and sequential random read, one bus step per input item.
// ----------------------------------------------------------------------------
// Each input item is one time-base tick and gives exactly one result item with
// the bus levels to drive after that tick. One item is taken per clock: the
// sequencer steps once per accepted item, and a two-deep output stage (result
// register plus skid register) keeps input acceptance going while a result
// waits, so s_tready drops only when both are full. A write request sends
// START, the device write address, address high byte, address low byte and
// data byte, then STOP; a read request sends a repeated START in place of
// the data byte, then the device read address and read_length bytes (zero
// as one, at most MAX_READ_LEN), the last one NACKed. Requests that arrive
// while a transaction runs are ignored. Write configuration registers only
// while no transaction runs and no result is pending.
module i2c_eeprom_master_core
    import iem_pkg::*;
#(
    parameter int MAX_READ_LEN = MAX_READ_LEN_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // tick items in
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [15:0] mem_addr, [23:16] write_data, [32:24] read_length, [33] sda_in
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // [1:0] action
    input  logic [IN_USER_W-1:0]  s_tuser,
    // result items out
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [0] scl_level, [1] sda_pull_low, [2] busy_res, [3] read_valid,
    // [11:4] read_byte, [12] ack_missing, [13] done_res
    output logic [OUT_DATA_W-1:0] m_tdata,
    // read_last
    output logic                  m_tlast
);

    cfg_t cfg_reg;
    res_t res;
    res_t main_reg;
    res_t skid_reg;
    logic main_valid_reg;
    logic skid_valid_reg;
    logic accept;

    // Hold the three registers; index three has no register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dev_addr    <= DEV_ADDR_RST;
            cfg_reg.phase_ticks <= PHASE_TICKS_RST;
            cfg_reg.ack_limit   <= ACK_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEV_ADDR:    cfg_reg.dev_addr    <= cfg_data[6:0];
                CFG_PHASE_TICKS: cfg_reg.phase_ticks <= cfg_data[9:0];
                CFG_ACK_LIMIT:   cfg_reg.ack_limit   <= cfg_data[9:0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    // Take an item whenever the skid register is free.
    assign s_tready = ~skid_valid_reg;
    assign accept   = s_tvalid & s_tready;

    iem_ctrl #(
        .MAX_READ_LEN (MAX_READ_LEN)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (accept),
        .action      (s_tuser[1:0]),
        .mem_addr    (s_tdata[15:0]),
        .write_data  (s_tdata[23:16]),
        .read_length (s_tdata[32:24]),
        .sda_in      (s_tdata[33]),
        .cfg         (cfg_reg),
        .res         (res)
    );

    // Output stage: advance the result register when it drains, park a new
    // result in the skid register while the consumer stalls.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!main_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= accept;
            end
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!main_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                main_reg <= skid_reg;
            end
            else if (accept)
            begin
                main_reg <= res;
            end
        end
        else if (accept)
        begin
            skid_reg <= res;
        end
    end

    assign m_tvalid = main_valid_reg;
    assign m_tlast  = main_reg.last;
    assign m_tdata  = {2'b00, main_reg.done, main_reg.ack_missing, main_reg.rbyte,
                       main_reg.valid, main_reg.busy, main_reg.pull, main_reg.scl};

endmodule

// ----- rtl/iem_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iem_checker: port-level checks of the I2C EEPROM master
// Watches the result stream for bus-level and flag consistency.
// ----------------------------------------------------------------------------
module iem_checker
    import iem_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  m_tlast
);

    // a finished STOP leaves the bus idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[13]) |-> (!m_tdata[2] && m_tdata[0] && !m_tdata[1]))
        else $error("done without idle bus");

    // while idle, clock stays high and data is released
    a_idle_levels: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[2]) |-> (m_tdata[0] && !m_tdata[1]))
        else $error("idle bus not released");

    // received byte and last mark only come with read_valid
    a_rx_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[3]) |-> (m_tdata[11:4] == 8'd0 && !m_tlast))
        else $error("stray read data");

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled result changed");

endmodule

bind i2c_eeprom_master_core iem_checker u_iem_checker (.*);

// ----- tb/iem_bus_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iem_bus_checker: bus level predictor and result checker
// Follows the I2C master one accepted tick at a time, queues the levels it
// expects and compares every result item against the oldest one.
// ----------------------------------------------------------------------------
module iem_bus_checker
    import iem_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    // [15:0] mem_addr, [23:16] write_data, [32:24] read_length, [33] sda_in
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // [1:0] action
    input  logic [IN_USER_W-1:0]  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    // [0] scl_level, [1] sda_pull_low, [2] busy_res, [3] read_valid,
    // [11:4] read_byte, [12] ack_missing, [13] done_res
    input  logic [OUT_DATA_W-1:0] m_tdata,
    // read_last
    input  logic                  m_tlast,
    output int unsigned           pending,
    output int unsigned           fail_count
);

    // register copies
    logic [6:0] dev_addr;
    logic [9:0] ticks_per_phase;
    logic [9:0] ack_limit;

    // sequencer copy
    phase_t     phase;
    stage_t     stage;
    logic [9:0] phase_cnt;
    logic [3:0] bit_cnt;
    logic [7:0] shreg;
    logic [8:0] bytes_left;
    logic [15:0] addr_hold;
    logic [7:0] data_hold;
    logic       reading;
    logic [9:0] ack_wait;
    logic       ack_err;

    res_t        bus_levels_q[$];
    int unsigned mismatches = 0;

    assign fail_count = mismatches;

    function automatic logic [7:0] stage_byte(stage_t s);
        case (s)
            STG_DEVW: return {dev_addr, 1'b0};
            STG_AHI:  return addr_hold[15:8];
            STG_ALO:  return addr_hold[7:0];
            STG_DATA: return data_hold;
            default:  return {dev_addr, 1'b1};
        endcase
    endfunction

    task automatic load_stage(input stage_t s);
        phase   = PH_TX_LOW;
        stage   = s;
        shreg   = stage_byte(s);
        bit_cnt = '0;
    endtask

    // move on once the device has acked (or the wait ran out)
    task automatic byte_acked();
        case (stage)
            STG_DEVW: load_stage(STG_AHI);
            STG_AHI:  load_stage(STG_ALO);
            STG_ALO:
                if (reading)
                    phase = PH_RS_LOW;
                else
                    load_stage(STG_DATA);
            STG_DATA: phase = PH_SP_LOW;
            default:
            begin
                phase   = PH_RX_LOW;
                bit_cnt = '0;
                shreg   = '0;
            end
        endcase
    endtask

    task automatic step_bus_master(
        input  logic [1:0]  act,
        input  logic [15:0] addr,
        input  logic [7:0]  wdata,
        input  logic [8:0]  len_in,
        input  logic        sda,
        output res_t        r
    );
        logic [9:0]  held_cnt;
        logic [10:0] next_cnt;
        logic [9:0]  len;
        r = '0;
        if (phase == PH_IDLE) begin
            if (act == ACT_WRITE || act == ACT_READ) begin
                len = (len_in == 9'd0) ? 10'd1 : {1'b0, len_in};
                if (len > MAX_READ_LEN_DEF)
                    len = 10'(MAX_READ_LEN_DEF);
                addr_hold  = addr;
                data_hold  = wdata;
                reading    = (act == ACT_READ);
                bytes_left = reading ? len[8:0] : 9'd0;
                ack_err    = 1'b0;
                ack_wait   = '0;
                bit_cnt    = '0;
                shreg      = '0;
                phase_cnt  = '0;
                phase      = PH_ST_HIGH;
            end
        end
        else begin
            held_cnt = phase_cnt;
            next_cnt = {1'b0, phase_cnt} + 11'd1;
            if (next_cnt < {1'b0, ticks_per_phase}) begin
                phase_cnt = next_cnt[9:0];
            end
            else begin
                phase_cnt = '0;
                case (phase)
                    PH_ST_HIGH: phase = PH_ST_FALL;
                    PH_ST_FALL: load_stage(STG_DEVW);
                    PH_RS_LOW:  phase = PH_RS_HIGH;
                    PH_RS_HIGH: phase = PH_RS_FALL;
                    PH_RS_FALL: load_stage(STG_DEVR);
                    PH_RX_LOW:  phase = PH_RX_HIGH;
                    PH_RX_HIGH:
                    begin
                        shreg   = {shreg[6:0], sda};
                        bit_cnt = bit_cnt + 4'd1;
                        if (bit_cnt >= 4'd8) begin
                            r.valid = 1'b1;
                            r.rbyte = shreg;
                            r.last  = (bytes_left <= 9'd1);
                            phase   = PH_MACK_LOW;
                        end
                        else begin
                            phase = PH_RX_LOW;
                        end
                    end
                    PH_MACK_LOW: phase = PH_MACK_HIGH;
                    PH_MACK_HIGH:
                    begin
                        if (bytes_left != 9'd0)
                            bytes_left = bytes_left - 9'd1;
                        if (bytes_left == 9'd0) begin
                            phase = PH_SP_LOW;
                        end
                        else begin
                            phase   = PH_RX_LOW;
                            bit_cnt = '0;
                            shreg   = '0;
                        end
                    end
                    PH_SP_LOW: phase = PH_SP_HIGH;
                    PH_SP_HIGH:
                    begin
                        phase  = PH_IDLE;
                        r.done = 1'b1;
                    end
                    PH_TX_LOW: phase = PH_TX_HIGH;
                    PH_TX_HIGH:
                    begin
                        shreg   = {shreg[6:0], 1'b0};
                        bit_cnt = bit_cnt + 4'd1;
                        phase   = (bit_cnt >= 4'd8) ? PH_ACK_LOW : PH_TX_LOW;
                    end
                    PH_ACK_LOW:
                    begin
                        ack_wait = '0;
                        phase    = PH_ACK_HIGH;
                    end
                    PH_ACK_HIGH:
                    begin
                        if (!sda) begin
                            byte_acked();
                        end
                        else begin
                            ack_wait = ack_wait + 10'd1;
                            if (ack_wait >= ack_limit) begin
                                ack_err = 1'b1;
                                byte_acked();
                            end
                            else begin
                                // stay at the end of the phase and sample again
                                phase_cnt = held_cnt;
                            end
                        end
                    end
                    default: phase = PH_IDLE;
                endcase
            end
        end

        r.scl  = 1'b1;
        r.pull = 1'b0;
        case (phase)
            PH_ST_FALL, PH_RS_FALL, PH_SP_HIGH: r.pull = 1'b1;
            PH_RS_LOW, PH_RX_LOW, PH_ACK_LOW:   r.scl = 1'b0;
            PH_MACK_LOW:
            begin
                r.scl  = 1'b0;
                r.pull = (bytes_left > 9'd1);
            end
            PH_MACK_HIGH: r.pull = (bytes_left > 9'd1);
            PH_SP_LOW:
            begin
                r.scl  = 1'b0;
                r.pull = 1'b1;
            end
            PH_TX_LOW:
            begin
                r.scl  = 1'b0;
                r.pull = ~shreg[7];
            end
            PH_TX_HIGH: r.pull = ~shreg[7];
            default: ;
        endcase
        r.busy        = (phase != PH_IDLE);
        r.ack_missing = ack_err;
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        res_t want;
        res_t got;
        res_t next_levels;
        if (!rst_n) begin
            dev_addr        = DEV_ADDR_RST;
            ticks_per_phase = PHASE_TICKS_RST;
            ack_limit       = ACK_LIMIT_RST;
            phase           = PH_IDLE;
            stage           = STG_DEVW;
            phase_cnt       = '0;
            bit_cnt         = '0;
            shreg           = '0;
            bytes_left      = '0;
            addr_hold       = '0;
            data_hold       = '0;
            reading         = 1'b0;
            ack_wait        = '0;
            ack_err         = 1'b0;
            bus_levels_q.delete();
            pending <= 0;
        end
        else begin
            if (m_tvalid && m_tready) begin
                got.scl         = m_tdata[0];
                got.pull        = m_tdata[1];
                got.busy        = m_tdata[2];
                got.valid       = m_tdata[3];
                got.rbyte       = m_tdata[11:4];
                got.ack_missing = m_tdata[12];
                got.done        = m_tdata[13];
                got.last        = m_tlast;
                if (bus_levels_q.size() == 0) begin
                    $error("result item arrived with nothing expected");
                    mismatches++;
                end
                else begin
                    want = bus_levels_q.pop_front();
                    check_field("scl_level", want.scl, got.scl);
                    check_field("sda_pull_low", want.pull, got.pull);
                    check_field("busy_res", want.busy, got.busy);
                    check_field("read_valid", want.valid, got.valid);
                    check_field("read_byte", want.rbyte, got.rbyte);
                    check_field("read_last", want.last, got.last);
                    check_field("ack_missing", want.ack_missing, got.ack_missing);
                    check_field("done_res", want.done, got.done);
                end
            end
            if (s_tvalid && s_tready) begin
                step_bus_master(s_tuser, s_tdata[15:0], s_tdata[23:16],
                                s_tdata[32:24], s_tdata[33], next_levels);
                bus_levels_q.push_back(next_levels);
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_DEV_ADDR:    dev_addr = cfg_data[6:0];
                    CFG_PHASE_TICKS: ticks_per_phase = cfg_data;
                    CFG_ACK_LIMIT:   ack_limit = cfg_data;
                    default: ;
                endcase
            end
            pending <= bus_levels_q.size();
        end
    end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the I2C EEPROM master core
// Drives tick items and requests with a simulated device answering on the
// data line, writes the registers between phases and lets the bus checker
// compare every result item against its own prediction.
// ----------------------------------------------------------------------------
module tb;
    import iem_pkg::*;

    // action code beyond the defined ones; the core must treat it as a tick
    localparam logic [1:0] ACT_SPARE = 2'd3;

    logic clk = 1'b0;
    logic rst_n;

    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    // [15:0] mem_addr, [23:16] write_data, [32:24] read_length, [33] sda_in
    logic [IN_DATA_W-1:0]  s_tdata;
    // [1:0] action
    logic [IN_USER_W-1:0]  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    // [0] scl_level, [1] sda_pull_low, [2] busy_res, [3] read_valid,
    // [11:4] read_byte, [12] ack_missing, [13] done_res
    logic [OUT_DATA_W-1:0] m_tdata;
    // read_last
    logic                  m_tlast;

    int unsigned pending;
    int unsigned fail_count;

    // stimulus knobs
    logic        idle_on   = 1'b1;   // random gaps on both sides
    logic        hold_long = 1'b0;   // ask the receiver for one long hold-off
    logic        last_busy = 1'b0;   // busy flag of the newest result seen
    int unsigned sda_low_pct = 100;  // chance the device pulls the data line low
    int unsigned calm_left = 0;      // items left in a gap-free stretch

    i2c_eeprom_master_core #(
        .MAX_READ_LEN (MAX_READ_LEN_DEF)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    iem_bus_checker bus_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .pending    (pending),
        .fail_count (fail_count)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Remember whether the newest result still showed a transaction running;
    // the stimulus uses it to keep ticking until the bus is back to idle.
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            last_busy <= m_tdata[2];
    end

    // Result side: random short stalls, stretches of steady acceptance, and
    // one long hold-off so the output stage fills and s_tready drops.
    initial
    begin : receiver
        bit          served;
        int unsigned held;
        served = 1'b0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_long && !served)
            begin
                served = 1'b1;
                m_tready <= 1'b0;
                for (held = 0; held < 64; held++)
                    @(posedge clk);
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            else if ($urandom_range(0, 15) == 0)
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(20, 60)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Device answer on the data line for one tick.
    function automatic logic pick_sda();
        return ($urandom_range(0, 99) < sda_low_pct) ? 1'b0 : 1'b1;
    endfunction

    // Offer one item and hold it until the core takes it. s_tvalid stays high
    // on return so back-to-back items need only one assignment per edge.
    task automatic push_item(
        input logic [1:0]  action,
        input logic [15:0] addr,
        input logic [7:0]  data,
        input logic [8:0]  len,
        input logic        sda
    );
        if (idle_on && calm_left == 0 && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        else if (calm_left != 0)
        begin
            calm_left--;
        end
        else if ($urandom_range(0, 31) == 0)
        begin
            calm_left = $urandom_range(20, 80);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= action;
        s_tdata  <= {{(IN_DATA_W - 34){1'b0}}, sda, len, data, addr};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Plain tick with random payload; the core uses only its sda_in bit.
    task automatic push_tick();
        push_item(($urandom_range(0, 7) == 0) ? ACT_SPARE : ACT_TICK,
                  16'($urandom_range(0, 65535)), 8'($urandom),
                  9'($urandom_range(0, 511)), pick_sda());
    endtask

    // Drop s_tvalid and wait for every expected result to come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // Keep ticking until the core reports idle with nothing in flight.
    task automatic run_to_idle();
        drain_results();
        while (last_busy)
        begin
            repeat (16) push_tick();
            drain_results();
        end
    endtask

    // Issue one request and tick it through to the end.
    task automatic do_request(
        input logic [1:0]  action,
        input logic [15:0] addr,
        input logic [7:0]  data,
        input logic [8:0]  len
    );
        push_item(action, addr, data, len, pick_sda());
        run_to_idle();
    endtask

    // Write all three registers; only done with the bus idle and drained.
    task automatic set_config(
        input logic [6:0] dev,
        input logic [9:0] ticks,
        input logic [9:0] limit
    );
        run_to_idle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DEV_ADDR;
        cfg_data  <= {3'b000, dev};
        @(posedge clk);
        cfg_index <= CFG_PHASE_TICKS;
        cfg_data  <= ticks;
        @(posedge clk);
        cfg_index <= CFG_ACK_LIMIT;
        cfg_data  <= limit;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Free-running traffic: mostly ticks, with requests sprinkled in. Those
    // landing mid-transaction must be ignored; the rest start a new one.
    task automatic random_traffic(input int unsigned n_ticks);
        int unsigned sent;
        int unsigned pick;
        sent = 0;
        while (sent < n_ticks)
        begin
            pick = $urandom_range(0, 15);
            if (pick == 0)
            begin
                push_item(ACT_WRITE, 16'($urandom_range(0, 65535)), 8'($urandom),
                          9'($urandom_range(0, 511)), pick_sda());
            end
            else if (pick == 1)
            begin
                push_item(ACT_READ, 16'($urandom_range(0, 65535)), 8'($urandom),
                          ($urandom_range(0, 9) == 0) ? 9'($urandom_range(0, 8))
                                                      : 9'($urandom_range(1, 4)),
                          pick_sda());
            end
            else
            begin
                push_tick();
                sent++;
            end
        end
    endtask

    initial
    begin : stimulus
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_DEV_ADDR;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= ACT_TICK;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Shorten the phase only; device address and ack limit keep their
        // reset values for the first write, the device mostly acking at once.
        cfg_we    <= 1'b1;
        cfg_index <= CFG_PHASE_TICKS;
        cfg_data  <= 10'd1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sda_low_pct = 90;
        do_request(ACT_WRITE, 16'hA55A, 8'h3C, 9'd1);

        // Highest device address, all-ones payload, then a write that never
        // gets an ack so every byte runs into the wait limit.
        set_config(7'h7F, 10'd1, 10'd2);
        sda_low_pct = 100;
        do_request(ACT_WRITE, 16'hFFFF, 8'hFF, 9'd1);
        sda_low_pct = 0;
        do_request(ACT_WRITE, 16'h0000, 8'h00, 9'd0);

        // Reads: single byte, zero length taken as one, and a read with no
        // device answering.
        sda_low_pct = 50;
        do_request(ACT_READ, 16'h1234, 8'h00, 9'd1);
        do_request(ACT_READ, 16'h8001, 8'hA5, 9'd0);
        sda_low_pct = 0;
        do_request(ACT_READ, 16'h00FF, 8'h00, 9'd3);

        // Requests during a running read are dropped; the spare action code
        // behaves as a tick both mid-transaction and while idle.
        sda_low_pct = 60;
        push_item(ACT_READ, 16'h00F0, 8'h5A, 9'd2, pick_sda());
        repeat (5) push_tick();
        push_item(ACT_WRITE, 16'hFFFF, 8'hFF, 9'd256, pick_sda());
        push_item(ACT_SPARE, 16'h0F0F, 8'h81, 9'd5, pick_sda());
        run_to_idle();
        push_item(ACT_SPARE, 16'h7777, 8'h11, 9'd7, pick_sda());
        run_to_idle();

        // Zero phase length and zero ack limit, lowest device address.
        set_config(7'h00, 10'd0, 10'd0);
        sda_low_pct = 40;
        do_request(ACT_WRITE, 16'h0102, 8'h7E, 9'd1);
        do_request(ACT_READ, 16'h0304, 8'h00, 9'd2);

        // Longer ack wait, device silent.
        set_config(7'h2A, 10'd1, 10'd12);
        sda_low_pct = 0;
        do_request(ACT_WRITE, 16'h5555, 8'hAA, 9'd1);

        // Random part. The first phase also carries the long result hold-off.
        set_config(7'($urandom), 10'($urandom_range(1, 2)), 10'($urandom_range(1, 6)));
        sda_low_pct = 75;
        hold_long <= 1'b1;
        random_traffic(100);

        set_config(7'($urandom), 10'd1, 10'd1);
        sda_low_pct = 50;
        random_traffic(100);

        set_config(7'($urandom), 10'd2, 10'($urandom_range(1, 1023)));
        sda_low_pct = 60;
        random_traffic(100);

        // Last stretch runs flat out on both sides.
        set_config(7'($urandom), 10'($urandom_range(1, 2)), 10'd3);
        sda_low_pct = 80;
        idle_on <= 1'b0;
        random_traffic(100);

        drain_results();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    // Watchdog: many times the slowest legal run.
    initial
    begin : watchdog
        #1_000_000;
        $display("tb failed");
        $finish;
    end

endmodule
